[hdl/tccp_pkg.sv]
// ----------------------------------------------------------------------------
// tccp_pkg
// Field widths and register indexes shared by the column placer files.
// ----------------------------------------------------------------------------
package tccp_pkg;

  localparam int COORD_W   = 20;
  localparam int CONTOUR_W = 21;
  localparam int HEIGHT_W  = 16;
  localparam int SHIFT_W   = 21;
  localparam int COL_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PITCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 3'd4;

  localparam logic [COORD_W-1:0]   COORD_MAX   = {COORD_W{1'b1}};
  localparam logic [CONTOUR_W-1:0] CONTOUR_MAX = {CONTOUR_W{1'b1}};

endpackage

[hdl/tccp_ram.sv]
// ----------------------------------------------------------------------------
// tccp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tetris_column_cluster_placer_core.sv]
// ----------------------------------------------------------------------------
// tetris_column_cluster_placer_core
// Tetris style column placer: scores every column by Manhattan distance,
// places the cluster on the cheapest column that fits and grows its contour.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, cluster fields       | sink
//  out     | out_valid/out_ready, placement fields   | source
//  cfg     | cfg_valid/cfg_ready, cfg_index/cfg_data | sink
//
//  an item is accepted in idle, then a single cost unit walks the contour ram
//  column by column in scan, with column_count clamped to 1..MAX_COLUMNS, and
//  the drain, fetch and write (result) states follow; the write registers the
//  result into the output register, which then shows it as valid
//  reset and first_of_pass clear the per-column valid bits at once, no sweep
//  in_ready is high only while idle; the write cycle waits while the output
//  register still holds an untaken result, and a new item may be accepted
//  while the last result waits
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module tetris_column_cluster_placer_core #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_first_of_pass,
  input  logic [tccp_pkg::COORD_W-1:0]     in_cluster_x,
  input  logic [tccp_pkg::COORD_W-1:0]     in_cluster_y,
  input  logic [tccp_pkg::HEIGHT_W-1:0]    in_cluster_height,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tccp_pkg::COL_W-1:0]       out_chosen_column,
  output logic [tccp_pkg::COORD_W-1:0]     out_placed_x,
  output logic [tccp_pkg::COORD_W-1:0]     out_placed_y,
  output logic signed [tccp_pkg::SHIFT_W-1:0] out_shift_x,
  output logic signed [tccp_pkg::SHIFT_W-1:0] out_shift_y,
  output logic                             out_overflow,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tccp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccp_pkg::COORD_W-1:0]     cfg_data
);

  import tccp_pkg::*;

  localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int EDGE_W = COORD_W + IDX_W + 1;
  localparam int COST_W = EDGE_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_FETCH  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [COORD_W-1:0] region_left_r, region_bottom_r, region_top_r, column_pitch_r;
  logic [COUNT_W-1:0] column_count_r;

  // item and scan registers
  logic [COORD_W-1:0]   cx_r, cy_r;
  logic [HEIGHT_W-1:0]  h_r;
  logic [COORD_W-1:0]   base_r;
  logic [MAX_COLUMNS-1:0] valid_r;
  logic [IDX_W-1:0]     last_r, idx_r, idx_d_r, best_r;
  logic [EDGE_W-1:0]    edge_r, edge_d_r, best_edge_r;
  logic [COST_W-1:0]    min_cost_r;
  logic                 found_r, pend_r, valid_d_r;

  // output registers
  logic                 out_valid_r;
  logic [COL_W-1:0]     out_col_r;
  logic [COORD_W-1:0]   out_px_r, out_py_r;
  logic [SHIFT_W-1:0]   out_sx_r, out_sy_r;
  logic                 out_ovf_r;

  // ram
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_raddr;
  logic [CONTOUR_W-1:0] mem_rdata, mem_wdata;

  logic                 in_acc;
  logic [COUNT_W-1:0]   count_m1;
  logic [IDX_W-1:0]     last_eff;
  logic [CONTOUR_W-1:0] cont;
  logic [CONTOUR_W:0]   cont_top;
  logic                 fits;
  logic [EDGE_W-1:0]    cx_ext, dx;
  logic [CONTOUR_W-1:0] cy_ext, dy;
  logic [COST_W-1:0]    cost;
  logic                 take;
  logic                 out_free;
  logic [CONTOUR_W:0]   grown;
  logic [COORD_W-1:0]   px, py;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign count_m1 = column_count_r - COUNT_W'(1);
  always_comb begin
    if (column_count_r == '0) begin
      last_eff = '0;
    end else if (int'(count_m1) >= MAX_COLUMNS) begin
      last_eff = IDX_W'(MAX_COLUMNS - 1);
    end else begin
      last_eff = IDX_W'(count_m1);
    end
  end

  // shared cost unit
  assign cont     = valid_d_r ? mem_rdata : CONTOUR_W'(base_r);
  assign cont_top = {1'b0, cont} + (CONTOUR_W + 1)'(h_r);
  assign fits     = cont_top <= (CONTOUR_W + 1)'(region_top_r);
  assign cx_ext   = EDGE_W'(cx_r);
  assign dx       = (cx_ext > edge_d_r) ? cx_ext - edge_d_r : edge_d_r - cx_ext;
  assign cy_ext   = CONTOUR_W'(cy_r);
  assign dy       = (cy_ext > cont) ? cy_ext - cont : cont - cy_ext;
  assign cost     = COST_W'(dx) + COST_W'(dy);
  assign take     = pend_r && fits && (!found_r || cost < min_cost_r);

  // result path
  assign grown     = {1'b0, cont} + (CONTOUR_W + 1)'(h_r);
  assign mem_wdata = grown[CONTOUR_W] ? CONTOUR_MAX : grown[CONTOUR_W-1:0];
  assign px        = (best_edge_r > EDGE_W'(COORD_MAX)) ? COORD_MAX
                                                         : best_edge_r[COORD_W-1:0];
  assign py        = cont[CONTOUR_W-1] ? COORD_MAX : cont[COORD_W-1:0];
  assign mem_we    = (state_r == S_RESULT) && out_free;
  assign mem_raddr = (state_r == S_SCAN) ? idx_r : best_r;

  tccp_ram #(
    .WIDTH (CONTOUR_W),
    .DEPTH (MAX_COLUMNS)
  ) u_contour_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (best_r),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SCAN;
      S_SCAN:   if (idx_r == last_r) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FETCH;
      S_FETCH:  state_nxt = S_RESULT;
      S_RESULT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      region_left_r   <= '0;
      region_bottom_r <= '0;
      region_top_r    <= COORD_MAX;
      column_pitch_r  <= COORD_W'(1);
      column_count_r  <= COUNT_W'(1);
      base_r          <= '0;
      valid_r         <= '0;
      pend_r          <= 1'b0;
      found_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REGION_LEFT:   region_left_r   <= cfg_data;
          REG_REGION_BOTTOM: region_bottom_r <= cfg_data;
          REG_REGION_TOP:    region_top_r    <= cfg_data;
          REG_COLUMN_PITCH:  column_pitch_r  <= cfg_data;
          REG_COLUMN_COUNT:  column_count_r  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && in_first_of_pass) begin
        valid_r <= '0;
        base_r  <= region_bottom_r;
      end
      if (mem_we) begin
        valid_r[best_r] <= 1'b1;
      end
      pend_r <= (state_r == S_SCAN);
      if (in_acc) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (mem_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    valid_d_r <= valid_r[mem_raddr];
    idx_d_r   <= idx_r;
    edge_d_r  <= edge_r;
    if (in_acc) begin
      cx_r        <= in_cluster_x;
      cy_r        <= in_cluster_y;
      h_r         <= in_cluster_height;
      last_r      <= last_eff;
      idx_r       <= '0;
      edge_r      <= EDGE_W'(region_left_r);
      best_r      <= '0;
      best_edge_r <= EDGE_W'(region_left_r);
      min_cost_r  <= '0;
    end else begin
      if (state_r == S_SCAN) begin
        idx_r  <= idx_r + IDX_W'(1);
        edge_r <= edge_r + EDGE_W'(column_pitch_r);
      end
      if (take) begin
        best_r      <= idx_d_r;
        best_edge_r <= edge_d_r;
        min_cost_r  <= cost;
      end
    end
    if (mem_we) begin
      out_col_r <= COL_W'(best_r);
      out_px_r  <= px;
      out_py_r  <= py;
      out_sx_r  <= {1'b0, px} - {1'b0, cx_r};
      out_sy_r  <= {1'b0, py} - {1'b0, cy_r};
      out_ovf_r <= !found_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_column = out_col_r;
  assign out_placed_x      = out_px_r;
  assign out_placed_y      = out_py_r;
  assign out_shift_x       = out_sx_r;
  assign out_shift_y       = out_sy_r;
  assign out_overflow      = out_ovf_r;

  // checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SCAN)
    else $error("item accepted without starting a scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= last_r)
    else $error("scan index beyond last column");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) && found_r |-> best_r <= last_r)
    else $error("chosen column beyond last column");

  a_write_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !out_valid_r || out_ready)
    else $error("result written while output slot busy");

endmodule

[tb/placement_checker.sv]
// ----------------------------------------------------------------------------
// placement_checker
// Watches the cluster, placement and register channels of the column placer.
// Keeps its own copy of the registers and the column contours, works out the
// placement of every accepted cluster and compares each placement taken from
// the block, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module placement_checker #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_first_of_pass,
  input  logic [tccp_pkg::COORD_W-1:0]        in_cluster_x,
  input  logic [tccp_pkg::COORD_W-1:0]        in_cluster_y,
  input  logic [tccp_pkg::HEIGHT_W-1:0]       in_cluster_height,

  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [tccp_pkg::COL_W-1:0]          out_chosen_column,
  input  logic [tccp_pkg::COORD_W-1:0]        out_placed_x,
  input  logic [tccp_pkg::COORD_W-1:0]        out_placed_y,
  input  logic signed [tccp_pkg::SHIFT_W-1:0] out_shift_x,
  input  logic signed [tccp_pkg::SHIFT_W-1:0] out_shift_y,
  input  logic                                out_overflow,

  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [tccp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tccp_pkg::COORD_W-1:0]        cfg_data,

  output int                                  placements_owed,
  output int                                  mismatches
);
  import tccp_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SHIFT_W-1:0] shift_x;
    logic [SHIFT_W-1:0] shift_y;
    logic               overflow;
  } placement_t;

  logic [COORD_W-1:0]   left_reg;
  logic [COORD_W-1:0]   bottom_reg;
  logic [COORD_W-1:0]   top_reg;
  logic [COORD_W-1:0]   pitch_reg;
  logic [COUNT_W-1:0]   count_reg;
  logic [CONTOUR_W-1:0] column_heights [MAX_COLUMNS];
  placement_t           placements_due [$];

  function automatic longint unsigned abs_gap(input longint unsigned a,
                                              input longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic placement_t place_cluster(input logic first,
                                               input logic [COORD_W-1:0] cx,
                                               input logic [COORD_W-1:0] cy,
                                               input logic [HEIGHT_W-1:0] h);
    placement_t        res;
    longint unsigned   cols, col_left, height, cont, cost, low_cost, grown, px, py;
    int                best;
    bit                found;
    if (first) begin
      foreach (column_heights[i]) column_heights[i] = CONTOUR_W'(bottom_reg);
    end
    if (count_reg == 0) cols = 1;
    else if (count_reg > MAX_COLUMNS) cols = MAX_COLUMNS;
    else cols = count_reg;
    height = h;
    found = 1'b0;
    best = 0;
    low_cost = 0;
    for (int i = 0; i < int'(cols); i++) begin
      col_left = longint'(left_reg) + longint'(i) * longint'(pitch_reg);
      cont = column_heights[i];
      if (cont + height <= top_reg) begin
        cost = abs_gap(cx, col_left) + abs_gap(cy, cont);
        if (!found || cost < low_cost) begin
          found = 1'b1;
          low_cost = cost;
          best = i;
        end
      end
    end
    col_left = longint'(left_reg) + longint'(best) * longint'(pitch_reg);
    py = column_heights[best];
    grown = py + height;
    column_heights[best] = (grown > CONTOUR_MAX) ? CONTOUR_MAX : CONTOUR_W'(grown);
    px = (col_left > COORD_MAX) ? COORD_MAX : col_left;
    if (py > COORD_MAX) py = COORD_MAX;
    res.column   = COL_W'(best);
    res.x        = COORD_W'(px);
    res.y        = COORD_W'(py);
    res.shift_x  = SHIFT_W'(px - cx);
    res.shift_y  = SHIFT_W'(py - cy);
    res.overflow = !found;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    placement_t want;
    if (!rst_n) begin
      left_reg   <= '0;
      bottom_reg <= '0;
      top_reg    <= COORD_MAX;
      pitch_reg  <= COORD_W'(1);
      count_reg  <= COUNT_W'(1);
      foreach (column_heights[i]) column_heights[i] = '0;
      placements_due.delete();
      placements_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REGION_LEFT:   left_reg   <= cfg_data;
          REG_REGION_BOTTOM: bottom_reg <= cfg_data;
          REG_REGION_TOP:    top_reg    <= cfg_data;
          REG_COLUMN_PITCH:  pitch_reg  <= cfg_data;
          REG_COLUMN_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (placements_due.size() == 0) begin
          $error("placement item with none outstanding");
          mismatches++;
        end else begin
          want = placements_due.pop_front();
          check_field("chosen_column", want.column, out_chosen_column);
          check_field("placed_x", want.x, out_placed_x);
          check_field("placed_y", want.y, out_placed_y);
          check_field("shift_x", $signed(want.shift_x), out_shift_x);
          check_field("shift_y", $signed(want.shift_y), out_shift_y);
          check_field("overflow", want.overflow, out_overflow);
        end
      end
      if (in_valid && in_ready) begin
        placements_due.insert(placements_due.size(),
                              place_cluster(in_first_of_pass, in_cluster_x,
                                            in_cluster_y, in_cluster_height));
      end
      placements_owed <= placements_due.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives clusters and register writes into the column placer, with the
// sender and the receiver idling at random in several phases, and gives the
// verdict from the placement checker's mismatch and owed-placement counts.
// ----------------------------------------------------------------------------
module testbench;
  import tccp_pkg::*;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 130;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_first_of_pass = 1'b0;
  logic [COORD_W-1:0]         in_cluster_x = '0;
  logic [COORD_W-1:0]         in_cluster_y = '0;
  logic [HEIGHT_W-1:0]        in_cluster_height = '0;

  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [COL_W-1:0]           out_chosen_column;
  logic [COORD_W-1:0]         out_placed_x;
  logic [COORD_W-1:0]         out_placed_y;
  logic signed [SHIFT_W-1:0]  out_shift_x;
  logic signed [SHIFT_W-1:0]  out_shift_y;
  logic                       out_overflow;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COORD_W-1:0]         cfg_data = '0;

  int                         placements_owed;
  int                         mismatches;
  int                         in_idle_pct = 0;
  int                         out_stall_pct = 0;

  longint unsigned            r_left = 0;
  longint unsigned            r_bottom = 0;
  longint unsigned            r_top = COORD_MAX;
  longint unsigned            r_pitch = 1;
  int                         r_cols = 1;

  tetris_column_cluster_placer_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_of_pass  (in_first_of_pass),
    .in_cluster_x      (in_cluster_x),
    .in_cluster_y      (in_cluster_y),
    .in_cluster_height (in_cluster_height),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chosen_column (out_chosen_column),
    .out_placed_x      (out_placed_x),
    .out_placed_y      (out_placed_y),
    .out_shift_x       (out_shift_x),
    .out_shift_y       (out_shift_y),
    .out_overflow      (out_overflow),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  placement_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_of_pass  (in_first_of_pass),
    .in_cluster_x      (in_cluster_x),
    .in_cluster_y      (in_cluster_y),
    .in_cluster_height (in_cluster_height),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chosen_column (out_chosen_column),
    .out_placed_x      (out_placed_x),
    .out_placed_y      (out_placed_y),
    .out_shift_x       (out_shift_x),
    .out_shift_y       (out_shift_y),
    .out_overflow      (out_overflow),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .placements_owed   (placements_owed),
    .mismatches        (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  function automatic logic [COORD_W-1:0] clip(input longint unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v[COORD_W-1:0];
  endfunction

  task automatic put_item(input logic first, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y, input logic [HEIGHT_W-1:0] h);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_first_of_pass  <= first;
    in_cluster_x      <= x;
    in_cluster_y      <= y;
    in_cluster_height <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_placements;
    in_valid <= 1'b0;
    do @(posedge clk); while (placements_owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_region(input longint unsigned left, input longint unsigned bottom,
                            input longint unsigned top, input longint unsigned pitch,
                            input logic [COORD_W-1:0] count_word);
    write_reg(REG_REGION_LEFT, clip(left));
    write_reg(REG_REGION_BOTTOM, clip(bottom));
    write_reg(REG_REGION_TOP, clip(top));
    write_reg(REG_COLUMN_PITCH, clip(pitch));
    write_reg(REG_COLUMN_COUNT, count_word);
    // unmapped index, must be ignored
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, COORD_W'($urandom()));
    cfg_valid <= 1'b0;
    r_left   = clip(left);
    r_bottom = clip(bottom);
    r_top    = clip(top);
    r_pitch  = clip(pitch);
    if (count_word[COUNT_W-1:0] == 0) r_cols = 1;
    else if (count_word[COUNT_W-1:0] > 64) r_cols = 64;
    else r_cols = count_word[COUNT_W-1:0];
  endtask

  task automatic setup_phase(input int idx);
    longint unsigned b;
    case (idx % 4)
      0: begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end
      1: begin
        in_idle_pct = 56;
        out_stall_pct = 0;
      end
      2: begin
        in_idle_pct = 0;
        out_stall_pct = 56;
      end
      default: begin
        in_idle_pct = 33;
        out_stall_pct = 33;
      end
    endcase
    b = $urandom_range(0, 600000);
    case (idx)
      0: set_region(0, 0, COORD_MAX, 1, 20'd1);
      1: set_region(1000, 200, 5000, 40, 20'd16);
      2: set_region(0, 0, COORD_MAX, 16384, 20'd64);
      3: set_region(1048000, 1000, 200000, 1000, 20'd8);
      4: set_region(5000, 0, 100000, 0, 20'd5);
      // zero count with junk above the field, every column overflowing
      5: set_region($urandom_range(0, COORD_MAX), COORD_MAX, 0, 7, 20'hABC00);
      6: set_region(COORD_MAX, 0, COORD_MAX, COORD_MAX, 20'd127);
      7: set_region(0, 500000, 500000, 3, 20'd12);
      default: set_region($urandom_range(0, COORD_MAX), b, b + $urandom_range(0, 448575),
                          $urandom_range(1) ? $urandom_range(0, 64)
                                            : $urandom_range(0, COORD_MAX),
                          COORD_W'($urandom()));
    endcase
  endtask

  task automatic run_phase(input int idx);
    int                  pass_left;
    longint unsigned     y_run, span, ystep, hmax, rh;
    logic                first;
    logic [COORD_W-1:0]  x, y;
    logic [HEIGHT_W-1:0] h;
    pass_left = 0;
    y_run = 0;
    rh = (r_top > r_bottom) ? r_top - r_bottom : 0;
    span = longint'(r_cols) * r_pitch;
    ystep = rh / 32 + 1;
    hmax = rh / 8 + 1;
    if (hmax > 65535) hmax = 65535;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (idx % 3 == 1 && k == PHASE_ITEMS / 2) wait_placements();
      if ($urandom_range(99) < 12) begin
        put_item(1'($urandom_range(1)), COORD_W'($urandom()), COORD_W'($urandom()),
                 HEIGHT_W'($urandom()));
      end else begin
        if (pass_left == 0) begin
          pass_left = $urandom_range(4, 40);
          y_run = r_bottom + $urandom_range(0, 64);
          first = (k == 0) ? 1'($urandom_range(1)) : 1'b1;
        end else begin
          first = 1'b0;
        end
        pass_left--;
        y_run += $urandom_range(1, ystep);
        x = clip(r_left + $urandom_range(0, span));
        y = clip(y_run);
        h = ($urandom_range(9) == 0) ? {HEIGHT_W{1'b1}} : HEIGHT_W'($urandom_range(0, hmax));
        put_item(first, x, y, h);
      end
    end
    wait_placements();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // registers at their reset values
    put_item(1'b1, 0, 0, 0);
    put_item(1'b0, COORD_MAX, COORD_MAX, {HEIGHT_W{1'b1}});
    put_item(1'b0, 0, COORD_MAX, {HEIGHT_W{1'b1}});
    wait_placements();

    // tie between two columns, then overflow to column 0
    set_region(100, 50, 1000, 10, 20'd4);
    put_item(1'b1, 115, 50, 10);
    put_item(1'b0, 115, 50, 10);
    put_item(1'b0, 0, 0, 2000);
    put_item(1'b0, 130, 1000, 0);
    wait_placements();

    // new bottom only applies at the next pass
    set_region(100, 300, 1000, 10, 20'd4);
    put_item(1'b0, 100, 50, 5);
    put_item(1'b1, 100, 300, 5);
    wait_placements();

    // zero count and zero pitch
    set_region(0, 0, COORD_MAX, 0, 20'd0);
    put_item(1'b1, 500, 500, 7);
    wait_placements();

    // count above the column limit
    set_region(0, 0, COORD_MAX, 0, 20'd100);
    put_item(1'b1, 500, 0, 7);
    put_item(1'b0, 0, 0, 7);
    wait_placements();

    // left edge past the coordinate range
    set_region(COORD_MAX, 0, COORD_MAX, COORD_MAX, 20'd3);
    put_item(1'b1, 0, 0, 1);
    put_item(1'b0, COORD_MAX, 0, 1);
    wait_placements();

    // contour past the coordinate range
    set_region(0, COORD_MAX, 0, 1, 20'd2);
    for (int i = 0; i < 4; i++) put_item(i == 0, 0, COORD_MAX, {HEIGHT_W{1'b1}});
    wait_placements();

    for (int p = 0; p < PHASES; p++) begin
      setup_phase(p);
      run_phase(p);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && placements_owed == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
